[rtl/ihs_pkg.sv]
package ihs_pkg;

  localparam int unsigned ITEM_W     = 10;
  localparam int unsigned ITEM_COUNT = 1024;
  localparam int unsigned SLOT_IN_W  = 11;
  localparam int unsigned KEY_IN_W   = 32;

  typedef enum logic [1:0] {
    FN_KEY   = 2'd0,
    FN_PLACE = 2'd1,
    FN_DOWN  = 2'd2,
    FN_UP    = 2'd3
  } func_e;

  typedef struct packed {
    func_e                        func;
    logic [SLOT_IN_W-1:0]         slot;
    logic [ITEM_W-1:0]            item;
    logic signed [KEY_IN_W-1:0]   key_value;
    logic [SLOT_IN_W-1:0]         count;
  } in_t;

  typedef struct packed {
    logic [SLOT_IN_W-1:0]         final_slot;
    logic [ITEM_W-1:0]            top_item;
    logic signed [KEY_IN_W-1:0]   top_key;
  } out_t;

  typedef enum logic [2:0] {
    SR_CUR,
    SR_CHILD,
    SR_RIGHT,
    SR_PARENT,
    SR_TOP
  } srd_sel_e;

  typedef enum logic [2:0] {
    SWR_NONE,
    SWR_DOWN,
    SWR_UP,
    SWR_MOV,
    SWR_ITEM
  } swr_sel_e;

  typedef struct packed {
    logic     init;
    srd_sel_e srd;
    swr_sel_e swr;
    logic     kwr;
    logic     ld_mov;
    logic     ld_mk;
    logic     ld_a;
    logic     ld_ka;
    logic     ld_b;
    logic     adv_down;
    logic     adv_up;
    logic     set_fin;
    logic     ld_top;
    logic     ld_topk;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  slot_ok;
    logic  child_gt_n;
    logic  stop_down;
    logic  parent_zero;
    logic  stop_up;
  } sts_t;

endpackage

[rtl/ihs_ram.sv]
module ihs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ihs_datapath.sv]
module ihs_datapath #(
  parameter int unsigned HEAP_SLOTS = 1024,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic          clk_i,
  input  ihs_pkg::in_t  in_i,
  input  ihs_pkg::cmd_t cmd_i,
  output ihs_pkg::sts_t sts_o,
  output ihs_pkg::out_t out_o
);
  import ihs_pkg::*;

  localparam int unsigned SW = $clog2(HEAP_SLOTS + 1) + 1;
  localparam int unsigned AW = $clog2(HEAP_SLOTS);
  localparam int unsigned KA = $clog2(ITEM_COUNT);

  func_e                    func_q;
  logic                     slot_ok_q;
  logic [SW-1:0]            cur_q, child_q, n_q, fin_q;
  logic [ITEM_W-1:0]        item_q, mov_q, ita_q, itb_q, top_item_q;
  logic signed [KEY_BITS-1:0] keyin_q, mk_q, ka_q, top_key_q;
  out_t                     out_q;

  logic [ITEM_W-1:0]        slot_rdata;
  logic signed [KEY_BITS-1:0] key_rdata;
  logic [SW-1:0]            rd_slot, rd_off, wr_off, child_r, pick_slot;
  logic [ITEM_W-1:0]        pick_item, swdata;
  logic signed [KEY_BITS-1:0] pick_key;
  logic                     has_right, take_right, swe;
  logic [31:0]              slot32, count32, ncl32, fin32;
  logic signed [63:0]       kin64, kout64;

  assign slot32  = 32'(in_i.slot);
  assign count32 = 32'(in_i.count);
  assign ncl32   = (count32 > HEAP_SLOTS) ? 32'(HEAP_SLOTS) : count32;
  assign kin64   = 64'(in_i.key_value);

  assign child_r    = child_q + SW'(1);
  assign has_right  = child_q < n_q;
  assign take_right = has_right && (key_rdata < ka_q);
  assign pick_slot  = take_right ? child_r : child_q;
  assign pick_item  = take_right ? itb_q : ita_q;
  assign pick_key   = take_right ? key_rdata : ka_q;

  always_comb begin
    case (cmd_i.srd)
      SR_CUR:    rd_slot = cur_q;
      SR_CHILD:  rd_slot = child_q;
      SR_RIGHT:  rd_slot = child_r;
      SR_PARENT: rd_slot = cur_q >> 1;
      SR_TOP:    rd_slot = SW'(1);
      default:   rd_slot = cur_q;
    endcase
  end

  assign rd_off = rd_slot - SW'(1);
  assign wr_off = cur_q - SW'(1);

  always_comb begin
    swe = 1'b1;
    case (cmd_i.swr)
      SWR_DOWN: swdata = pick_item;
      SWR_UP:   swdata = ita_q;
      SWR_MOV:  swdata = mov_q;
      SWR_ITEM: swdata = item_q;
      default: begin
        swe    = 1'b0;
        swdata = mov_q;
      end
    endcase
  end

  ihs_ram #(.WIDTH(ITEM_W), .DEPTH(HEAP_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (swe),
    .waddr_i (wr_off[AW-1:0]),
    .wdata_i (swdata),
    .raddr_i (rd_off[AW-1:0]),
    .rdata_o (slot_rdata)
  );

  ihs_ram #(.WIDTH(KEY_BITS), .DEPTH(ITEM_COUNT)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.kwr),
    .waddr_i (item_q[KA-1:0]),
    .wdata_i (keyin_q),
    .raddr_i (slot_rdata[KA-1:0]),
    .rdata_o (key_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      func_q    <= in_i.func;
      slot_ok_q <= (slot32 != 32'd0) && (slot32 <= HEAP_SLOTS);
      cur_q     <= slot32[SW-1:0];
      child_q   <= SW'(slot32 << 1);
      n_q       <= ncl32[SW-1:0];
      item_q    <= in_i.item;
      keyin_q   <= kin64[KEY_BITS-1:0];
      fin_q     <= '0;
    end
    if (cmd_i.ld_mov) mov_q <= slot_rdata;
    if (cmd_i.ld_mk)  mk_q  <= key_rdata;
    if (cmd_i.ld_a)   ita_q <= slot_rdata;
    if (cmd_i.ld_ka)  ka_q  <= key_rdata;
    if (cmd_i.ld_b)   itb_q <= slot_rdata;
    if (cmd_i.adv_down) begin
      cur_q   <= pick_slot;
      child_q <= pick_slot << 1;
    end
    if (cmd_i.adv_up)  cur_q      <= cur_q >> 1;
    if (cmd_i.set_fin) fin_q      <= cur_q;
    if (cmd_i.ld_top)  top_item_q <= slot_rdata;
    if (cmd_i.ld_topk) top_key_q  <= key_rdata;
    if (cmd_i.ld_out) begin
      out_q.final_slot <= fin32[SLOT_IN_W-1:0];
      out_q.top_item   <= top_item_q;
      out_q.top_key    <= kout64[KEY_IN_W-1:0];
    end
  end

  assign fin32  = 32'(fin_q);
  assign kout64 = 64'(top_key_q);

  assign sts_o.func        = func_q;
  assign sts_o.slot_ok     = slot_ok_q;
  assign sts_o.child_gt_n  = child_q > n_q;
  assign sts_o.stop_down   = mk_q <= pick_key;
  assign sts_o.parent_zero = (cur_q >> 1) == '0;
  assign sts_o.stop_up     = key_rdata <= mk_q;

  assign out_o = out_q;

endmodule

[rtl/ihs_ctrl.sv]
module ihs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ihs_pkg::sts_t sts_i,
  output ihs_pkg::cmd_t cmd_o
);
  import ihs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_KW, ST_PL, ST_LD0, ST_LD1, ST_LD2,
    ST_DCHK, ST_DL1, ST_DL2, ST_DL3, ST_UCHK, ST_UP1, ST_UP2,
    ST_PUT, ST_TOP0, ST_TOP1, ST_TOP2, ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.srd  = SR_TOP;
    cmd_o.swr  = SWR_NONE;
    case (state_q)
      ST_IDLE: cmd_o.init = in_valid_i;
      ST_KW:   cmd_o.kwr  = 1'b1;
      ST_PL: begin
        cmd_o.swr     = SWR_ITEM;
        cmd_o.set_fin = 1'b1;
      end
      ST_LD0:  cmd_o.srd    = SR_CUR;
      ST_LD1:  cmd_o.ld_mov = 1'b1;
      ST_LD2:  cmd_o.ld_mk  = 1'b1;
      ST_DCHK: cmd_o.srd    = SR_CHILD;
      ST_DL1: begin
        cmd_o.ld_a = 1'b1;
        cmd_o.srd  = SR_RIGHT;
      end
      ST_DL2: begin
        cmd_o.ld_ka = 1'b1;
        cmd_o.ld_b  = 1'b1;
      end
      ST_DL3: begin
        if (!sts_i.stop_down) begin
          cmd_o.swr      = SWR_DOWN;
          cmd_o.adv_down = 1'b1;
        end
      end
      ST_UCHK: cmd_o.srd  = SR_PARENT;
      ST_UP1:  cmd_o.ld_a = 1'b1;
      ST_UP2: begin
        if (!sts_i.stop_up) begin
          cmd_o.swr    = SWR_UP;
          cmd_o.adv_up = 1'b1;
        end
      end
      ST_PUT: begin
        cmd_o.swr     = SWR_MOV;
        cmd_o.set_fin = 1'b1;
      end
      ST_TOP1: cmd_o.ld_top  = 1'b1;
      ST_TOP2: cmd_o.ld_topk = 1'b1;
      ST_OUT:  cmd_o.ld_out  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_DISP;
        ST_DISP: begin
          if (sts_i.func == FN_KEY)  state_q <= ST_KW;
          else if (!sts_i.slot_ok)   state_q <= ST_TOP0;
          else if (sts_i.func == FN_PLACE) state_q <= ST_PL;
          else                       state_q <= ST_LD0;
        end
        ST_KW:   state_q <= ST_TOP0;
        ST_PL:   state_q <= ST_TOP0;
        ST_LD0:  state_q <= ST_LD1;
        ST_LD1:  state_q <= ST_LD2;
        ST_LD2:  state_q <= (sts_i.func == FN_DOWN) ? ST_DCHK : ST_UCHK;
        ST_DCHK: state_q <= sts_i.child_gt_n ? ST_PUT : ST_DL1;
        ST_DL1:  state_q <= ST_DL2;
        ST_DL2:  state_q <= ST_DL3;
        ST_DL3:  state_q <= sts_i.stop_down ? ST_PUT : ST_DCHK;
        ST_UCHK: state_q <= sts_i.parent_zero ? ST_PUT : ST_UP1;
        ST_UP1:  state_q <= ST_UP2;
        ST_UP2:  state_q <= sts_i.stop_up ? ST_PUT : ST_UCHK;
        ST_PUT:  state_q <= ST_TOP0;
        ST_TOP0: state_q <= ST_TOP1;
        ST_TOP1: state_q <= ST_TOP2;
        ST_TOP2: state_q <= ST_OUT;
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/indexed_heap_sift.sv]
// channel | signals                      | fires when
// in      | in_valid_i in_ready_o in_i   | in_valid_i && in_ready_o
// out     | out_valid_o out_ready_i out_o| out_valid_o && out_ready_i
//
// One item at a time: in_ready_o is high only in idle, until the last result is loaded.
// A sift loads the moving item and its key, then compares children (down) or the parent
// (up) a level at a time, and stops when the order holds or at the last child or the root.
// Per level cost is the registered slot RAM read feeding the key RAM lookup.
// rst_ni clears control only; the RAMs need writing before they are read.
// A result held by out_ready_i stalls the next item in its last cycle.
module indexed_heap_sift #(
  parameter int unsigned HEAP_SLOTS = 1024,
  parameter int unsigned KEY_BITS   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ihs_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ihs_pkg::out_t out_o
);
  import ihs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ihs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ihs_datapath #(.HEAP_SLOTS(HEAP_SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk_i (clk_i),
    .in_i  (in_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (out_o)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ihs_pkg::*;

  typedef struct {
    out_t res;
    bit   top_known;
  } heap_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  indexed_heap_sift dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow heap
  logic signed [31:0] key_mem   [ITEM_COUNT];
  logic [9:0]         slot_mem  [1024];
  logic [10:0]        pos_mem   [ITEM_COUNT];
  bit                 key_ok    [ITEM_COUNT];
  bit                 slot_ok_w [1024];
  logic signed [31:0] key_sav   [ITEM_COUNT];
  logic [9:0]         slot_sav  [1024];
  logic [10:0]        pos_sav   [ITEM_COUNT];
  bit                 key_ok_sav[ITEM_COUNT];
  bit                 slot_ok_sav[1024];
  bit                 rd_bad;

  heap_exp_t results_due[$];
  heap_exp_t got_exp;
  int errs = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic [9:0] slot_at(input int s);
    if (!slot_ok_w[s-1]) rd_bad = 1'b1;
    return slot_mem[s-1];
  endfunction

  function automatic logic signed [31:0] key_of(input logic [9:0] it);
    if (!key_ok[it]) rd_bad = 1'b1;
    return key_mem[it];
  endfunction

  function automatic void put_slot(input int s, input logic [9:0] it);
    slot_mem[s-1] = it;
    slot_ok_w[s-1] = 1'b1;
    pos_mem[it] = s[10:0];
  endfunction

  function automatic heap_exp_t heap_apply(input in_t x);
    heap_exp_t e;
    int cnt, cur, ch, par, fin;
    logic [9:0] mv;
    logic signed [31:0] mk;
    rd_bad = 1'b0;
    fin = 0;
    cnt = (int'(x.count) > 1024) ? 1024 : int'(x.count);
    if (x.func == FN_KEY) begin
      key_mem[x.item] = x.key_value;
      key_ok[x.item] = 1'b1;
    end else if (x.slot >= 1 && x.slot <= 1024) begin
      cur = int'(x.slot);
      case (x.func)
        FN_PLACE: begin
          put_slot(cur, x.item);
        end
        FN_DOWN: begin
          mv = slot_at(cur);
          mk = key_of(mv);
          ch = 2 * cur;
          while (ch <= cnt) begin
            if (ch < cnt && key_of(slot_at(ch + 1)) < key_of(slot_at(ch))) ch = ch + 1;
            if (mk <= key_of(slot_at(ch))) break;
            put_slot(cur, slot_at(ch));
            cur = ch;
            ch = 2 * cur;
          end
          put_slot(cur, mv);
        end
        default: begin
          mv = slot_at(cur);
          mk = key_of(mv);
          par = cur / 2;
          while (par > 0) begin
            if (key_of(slot_at(par)) <= mk) break;
            put_slot(cur, slot_at(par));
            cur = par;
            par = cur / 2;
          end
          put_slot(cur, mv);
        end
      endcase
      fin = cur;
    end
    e.res.final_slot = fin[10:0];
    e.res.top_item = slot_mem[0];
    e.res.top_key = key_mem[slot_mem[0]];
    e.top_known = slot_ok_w[0] && key_ok[slot_mem[0]];
    return e;
  endfunction

  task automatic send_item(input in_t x, input heap_exp_t e);
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    results_due.push_back(e);
    in_valid_i <= 1'b1;
    in_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic issue(input func_e f, input int s, input int it, input int k, input int c);
    in_t x;
    x.func = f;
    x.slot = s[10:0];
    x.item = it[9:0];
    x.key_value = k;
    x.count = c[10:0];
    send_item(x, heap_apply(x));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        $error("result with nothing expected: %h", out_o);
        errs++;
      end else begin
        got_exp = results_due.pop_front();
        if (out_o.final_slot !== got_exp.res.final_slot) begin
          $error("final_slot exp %0d got %0d", got_exp.res.final_slot, out_o.final_slot);
          errs++;
        end
        if (got_exp.top_known && out_o.top_item !== got_exp.res.top_item) begin
          $error("top_item exp %0d got %0d", got_exp.res.top_item, out_o.top_item);
          errs++;
        end
        if (got_exp.top_known && out_o.top_key !== got_exp.res.top_key) begin
          $error("top_key exp %0d got %0d", got_exp.res.top_key, out_o.top_key);
          errs++;
        end
      end
    end
  end

  task automatic test_edge_cases();
    issue(FN_KEY, 0, 5, 32'sh7FFFFFFF, 0);
    issue(FN_PLACE, 1, 5, 0, 0);
    issue(FN_KEY, 0, 1023, 32'sh80000000, 0);
    issue(FN_KEY, 0, 0, 0, 0);
    issue(FN_KEY, 0, 682, -1, 0);
    issue(FN_KEY, 0, 341, 1, 0);
    issue(FN_PLACE, 2, 1023, 0, 0);
    issue(FN_PLACE, 3, 0, 0, 0);
    issue(FN_PLACE, 4, 682, 0, 0);
    issue(FN_PLACE, 5, 341, 0, 0);
    issue(FN_UP, 2, 0, 0, 0);
    issue(FN_DOWN, 2, 0, 0, 5);
    issue(FN_DOWN, 3, 0, 0, 2);
    issue(FN_DOWN, 1, 0, 0, 2047);
    issue(FN_KEY, 0, 0, -1, 0);
    issue(FN_DOWN, 1, 0, 0, 5);
    issue(FN_UP, 5, 0, 0, 0);
    issue(FN_DOWN, 1, 0, 0, 0);
    issue(FN_PLACE, 0, 7, 0, 3);
    issue(FN_DOWN, 2047, 0, 0, 5);
    issue(FN_UP, 1025, 0, 0, 0);
    issue(FN_PLACE, 1024, 1023, 0, 0);
    issue(FN_DOWN, 1024, 0, 0, 2047);
    issue(FN_KEY, 0, 1023, 32'sh7FFFFFFF, 0);
    wait_drained();
  endtask

  function automatic int pick_item();
    return ($urandom_range(99) < 80) ? int'($urandom_range(47)) : int'($urandom_range(1023));
  endfunction

  task automatic test_random_heap(input int n_items, input int sp, input int rp);
    in_t x;
    heap_exp_t e;
    int tries, r;
    send_idle_pct = sp;
    recv_stall_pct = rp;
    repeat (n_items) begin
      tries = 0;
      do begin
        key_sav = key_mem; slot_sav = slot_mem; pos_sav = pos_mem;
        key_ok_sav = key_ok; slot_ok_sav = slot_ok_w;
        x.item = 10'(pick_item());
        x.key_value = ($urandom_range(1)) ? $urandom : $signed($urandom_range(8)) - 4;
        x.count = 11'($urandom_range(40));
        x.slot = ($urandom_range(99) < 90) ? 11'($urandom_range(1, 40))
                                           : 11'($urandom_range(1, 1024));
        r = int'($urandom_range(99));
        if (tries > 40 || r < 20) begin
          x.func = FN_KEY;
          if (tries > 40) x.item = slot_mem[0];
          if ($urandom_range(9) == 0) x.slot = 11'($urandom);
        end else if (r < 45) begin
          x.func = FN_PLACE;
        end else if (r < 70) begin
          x.func = FN_DOWN;
          if ($urandom_range(9) == 0) x.count = 11'($urandom_range(1025, 2047));
        end else if (r < 92) begin
          x.func = FN_UP;
        end else begin
          x.func = func_e'($urandom_range(1, 3));
          x.slot = ($urandom_range(1)) ? 11'd0 : 11'($urandom_range(1025, 2047));
          x.count = 11'($urandom);
        end
        e = heap_apply(x);
        if (rd_bad || !e.top_known) begin
          key_mem = key_sav; slot_mem = slot_sav; pos_mem = pos_sav;
          key_ok = key_ok_sav; slot_ok_w = slot_ok_sav;
        end
        tries++;
      end while (rd_bad || !e.top_known);
      send_item(x, e);
    end
  endtask

  task automatic test_idle_pause();
    wait_drained();
    test_random_heap(10, 0, 0);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    test_random_heap(110, 0, 0);
    test_idle_pause();
    test_random_heap(110, 86, 0);
    test_random_heap(110, 0, 86);
    test_random_heap(110, 11, 11);
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errs == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
